### rtl/btcp_pkg.sv
// Shared types, register indexes and fixed-point helpers for the binomial call pricer.
package btcp_pkg;

  localparam int unsigned PriceW  = 32;
  localparam int unsigned FactorW = 32;
  localparam int unsigned ProbW   = 31;
  localparam int unsigned StepW   = 9;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 32;
  localparam int unsigned ProdW   = 64;

  localparam logic [CfgIdxW-1:0] CFG_STEP_COUNT      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_UP_FACTOR       = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DOWN_FACTOR     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_UP_PROBABILITY  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DISCOUNT_FACTOR = 3'd4;

  localparam logic [ProbW-1:0] OneQ30 = 31'h4000_0000;

  localparam logic [StepW-1:0]   StepReset   = 9'd100;
  localparam logic [FactorW-1:0] UpReset     = 32'h4000_0000;
  localparam logic [FactorW-1:0] DownReset   = 32'h4000_0000;
  localparam logic [ProbW-1:0]   ProbReset   = 31'h2000_0000;
  localparam logic [ProbW-1:0]   DiscReset   = 31'h4000_0000;

  typedef struct packed {
    logic [PriceW-1:0] spot_price;
    logic [PriceW-1:0] strike_price;
  } req_t;

  typedef struct packed {
    logic [PriceW-1:0] option_price;
  } rsp_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] reg_index;
    logic [CfgDatW-1:0] wr_data;
  } cfg_t;

  // Q30 product back to Q16.16 price, truncated and saturated to 32 bits
  function automatic logic [PriceW-1:0] sat_q30(input logic [ProdW-1:0] x);
    logic [PriceW-1:0] r;
    if (x[63:62] != 2'b00) begin
      r = '1;
    end else begin
      r = x[61:30];
    end
    return r;
  endfunction

endpackage

### rtl/btcp_if.sv
// Valid/ready channel interfaces for requests, results and register writes.
interface btcp_req_if;
  logic              valid;
  logic              ready;
  btcp_pkg::req_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface btcp_rsp_if;
  logic              valid;
  logic              ready;
  btcp_pkg::rsp_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface btcp_cfg_if;
  logic              valid;
  logic              ready;
  btcp_pkg::cfg_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/binomial_tree_call_pricer.sv
// With n steps the leaves are priced, then the tree is folded back to the root;
// n = 0 answers zero. The result waits in its output register until taken.
// Throughput: one item at a time, the next accepted after the result transfer.
// A single 32x32 multiplier, one product per cycle, is shared by leaf pricing and
// the backward fold. Reset clears control and loads register defaults;
// the claim memory is not cleared, every entry is written before it is read.
module binomial_tree_call_pricer #(
  parameter int unsigned MAX_STEPS = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  btcp_req_if.sink        req_i,
  btcp_rsp_if.source      rsp_o,
  btcp_cfg_if.sink        cfg_i
);

  localparam int unsigned Depth = MAX_STEPS + 1;
  localparam int unsigned CntW  = $clog2(MAX_STEPS + 1);
  localparam logic [CntW-1:0] MaxN = CntW'(MAX_STEPS);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_LEAF   = 11'b000_0000_0010,
    S_LWR    = 11'b000_0000_0100,
    S_FSTART = 11'b000_0000_1000,
    S_FLOW   = 11'b000_0001_0000,
    S_FA     = 11'b000_0010_0000,
    S_FB     = 11'b000_0100_0000,
    S_FC     = 11'b000_1000_0000,
    S_FD     = 11'b001_0000_0000,
    S_FE     = 11'b010_0000_0000,
    S_OUT    = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [btcp_pkg::StepW-1:0]   steps_q;
  logic [btcp_pkg::FactorW-1:0] up_q;
  logic [btcp_pkg::FactorW-1:0] down_q;
  logic [btcp_pkg::ProbW-1:0]   prob_q;
  logic [btcp_pkg::ProbW-1:0]   disc_q;

  logic [CntW-1:0] n_q, n_d;
  logic [CntW-1:0] j_q, j_d;
  logic [CntW-1:0] k_q, k_d;
  logic [CntW-1:0] t_q, t_d;
  logic [CntW-1:0] b_q, b_d;

  logic [btcp_pkg::PriceW-1:0] spot_q, strike_q, lower_q, upper_q, out_q, rd_q;
  logic [btcp_pkg::ProdW-1:0]  prod_q, acc_q;

  logic [btcp_pkg::PriceW-1:0] mem [Depth];

  logic                        req_xfer;
  logic                        cfg_xfer;
  logic [btcp_pkg::ProbW-1:0]  q_eff;
  logic [btcp_pkg::ProbW-1:0]  qc;
  logic [btcp_pkg::PriceW-1:0] p_cur;
  logic [btcp_pkg::PriceW-1:0] leaf_claim;
  logic                        use_down;
  logic [btcp_pkg::PriceW-1:0] mul_a;
  logic [btcp_pkg::PriceW-1:0] mul_b;
  logic                        mul_en;
  logic                        mem_we;
  logic [CntW-1:0]             wr_addr;
  logic [btcp_pkg::PriceW-1:0] wr_data;
  logic [CntW-1:0]             rd_addr;

  assign req_xfer = req_i.valid && req_i.ready;
  assign cfg_xfer = cfg_i.valid && cfg_i.ready;

  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = (state_q == S_OUT);
  assign rsp_o.data.option_price = out_q;

  assign q_eff = (prob_q > btcp_pkg::OneQ30) ? btcp_pkg::OneQ30 : prob_q;
  assign qc    = btcp_pkg::OneQ30 - q_eff;
  assign p_cur = btcp_pkg::sat_q30(prod_q);
  assign leaf_claim = (p_cur > strike_q) ? (p_cur - strike_q) : '0;
  assign use_down = ({1'b0, k_q} + {1'b0, j_q}) < {1'b0, n_q};

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= btcp_pkg::StepReset;
      up_q    <= btcp_pkg::UpReset;
      down_q  <= btcp_pkg::DownReset;
      prob_q  <= btcp_pkg::ProbReset;
      disc_q  <= btcp_pkg::DiscReset;
    end else if (cfg_xfer) begin
      unique case (cfg_i.data.reg_index)
        btcp_pkg::CFG_STEP_COUNT:      steps_q <= cfg_i.data.wr_data[btcp_pkg::StepW-1:0];
        btcp_pkg::CFG_UP_FACTOR:       up_q    <= cfg_i.data.wr_data;
        btcp_pkg::CFG_DOWN_FACTOR:     down_q  <= cfg_i.data.wr_data;
        btcp_pkg::CFG_UP_PROBABILITY:  prob_q  <= cfg_i.data.wr_data[btcp_pkg::ProbW-1:0];
        btcp_pkg::CFG_DISCOUNT_FACTOR: disc_q  <= cfg_i.data.wr_data[btcp_pkg::ProbW-1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier operand select and memory port control
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_en  = 1'b0;
    mem_we  = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    rd_addr = '0;
    unique case (state_q)
      S_LEAF: begin
        mul_en = 1'b1;
        mul_a  = (k_q == '0) ? spot_q : p_cur;
        mul_b  = use_down ? down_q : up_q;
      end
      S_LWR: begin
        mem_we  = 1'b1;
        wr_addr = j_q;
        wr_data = leaf_claim;
      end
      S_FSTART: rd_addr = '0;
      S_FLOW:   rd_addr = b_q + CntW'(1);
      S_FA: begin
        mul_en = 1'b1;
        mul_a  = rd_q;
        mul_b  = {1'b0, q_eff};
      end
      S_FB: begin
        mul_en = 1'b1;
        mul_a  = lower_q;
        mul_b  = {1'b0, qc};
      end
      S_FD: begin
        mul_en = 1'b1;
        mul_a  = acc_q[61:30];
        mul_b  = {1'b0, disc_q};
      end
      S_FE: begin
        mem_we  = 1'b1;
        wr_addr = b_q;
        wr_data = p_cur;
        if ((b_q + CntW'(1)) != t_q) begin
          rd_addr = b_q + CntW'(2);
        end
      end
      S_IDLE, S_FC, S_OUT: ;
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    n_d = n_q;
    j_d = j_q;
    k_d = k_q;
    t_d = t_q;
    b_d = b_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_xfer) begin
          n_d = (32'(steps_q) > 32'(MAX_STEPS)) ? MaxN : CntW'(steps_q);
          j_d = '0;
          k_d = '0;
          state_d = (steps_q == '0) ? S_OUT : S_LEAF;
        end
      end
      S_LEAF: begin
        if (k_q == n_q - CntW'(1)) begin
          state_d = S_LWR;
        end else begin
          k_d = k_q + CntW'(1);
        end
      end
      S_LWR: begin
        k_d = '0;
        if (j_q == n_q) begin
          t_d = n_q;
          b_d = '0;
          state_d = S_FSTART;
        end else begin
          j_d = j_q + CntW'(1);
          state_d = S_LEAF;
        end
      end
      S_FSTART: state_d = S_FLOW;
      S_FLOW:   state_d = S_FA;
      S_FA:     state_d = S_FB;
      S_FB:     state_d = S_FC;
      S_FC:     state_d = S_FD;
      S_FD:     state_d = S_FE;
      S_FE: begin
        if ((b_q + CntW'(1)) == t_q) begin
          b_d = '0;
          if (t_q == CntW'(1)) begin
            state_d = S_OUT;
          end else begin
            t_d = t_q - CntW'(1);
            state_d = S_FSTART;
          end
        end else begin
          b_d = b_q + CntW'(1);
          state_d = S_FA;
        end
      end
      S_OUT: begin
        if (rsp_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      n_q <= '0;
      j_q <= '0;
      k_q <= '0;
      t_q <= '0;
      b_q <= '0;
    end else begin
      state_q <= state_d;
      n_q <= n_d;
      j_q <= j_d;
      k_q <= k_d;
      t_q <= t_d;
      b_q <= b_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      spot_q   <= req_i.data.spot_price;
      strike_q <= req_i.data.strike_price;
    end
    if (mul_en) begin
      prod_q <= btcp_pkg::ProdW'(mul_a) * btcp_pkg::ProdW'(mul_b);
    end
    if (state_q == S_FB) begin
      acc_q <= prod_q;
    end else if (state_q == S_FC) begin
      acc_q <= acc_q + prod_q;
    end
    if (state_q == S_FLOW) begin
      lower_q <= rd_q;
    end else if (state_q == S_FE) begin
      lower_q <= upper_q;
    end
    if (state_q == S_FA) begin
      upper_q <= rd_q;
    end
    if (req_xfer && (steps_q == '0)) begin
      out_q <= '0;
    end else if ((state_q == S_FE) && (t_q == CntW'(1))) begin
      out_q <= p_cur;
    end
  end

  // claim memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (wr_addr <= n_q))
    else $error("claim write beyond tree width");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FA) |-> ((b_q < t_q) && (t_q <= n_q)))
    else $error("fold node index out of pass range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !req_i.ready)
    else $error("request taken while result pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_xfer && (steps_q == '0)) |=> (rsp_o.valid && (rsp_o.data.option_price == '0)))
    else $error("zero-step request not answered with zero");

endmodule
